[hw/rtl/fsbd_pkg.sv]
// Shared constants, types and widths of the one-bit Floyd-Steinberg dither.
package fsbd_pkg;

  // Longest row that the line store holds.
  localparam int unsigned LINE_MAX = 512;
  localparam int unsigned COL_W    = $clog2(LINE_MAX);

  // Width of the line_width register and its reset value.
  localparam int unsigned CFG_W = 10;
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(512);

  // Width used to compare a column against the effective row width.
  localparam int unsigned CMP_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam logic [CMP_W-1:0] WIDTH_MIN = CMP_W'(8);
  localparam logic [CMP_W-1:0] WIDTH_LIM = CMP_W'(LINE_MAX & ~7);

  localparam int unsigned PIX_W = 8;
  localparam int unsigned ERR_W = 9;  // stored error, signed -256..255
  localparam int unsigned RE_W  = 7;  // right error 7q, signed -56..49
  localparam int unsigned Q_W   = 4;  // error share q, signed -8..7

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [RE_W-1:0]  rerr_t;
  typedef logic signed [Q_W-1:0]   share_t;

  // Everything the quantizer hands back for one pixel.
  typedef struct packed {
    logic  white;       // thresholded pixel, 1 means white
    share_t q;          // error share, kept as the next below-right term
    rerr_t  right_err;  // 7q for the next pixel in the row
    err_t   below_new;  // below-right of the previous pixel plus 5q
    err_t   below_left; // held entry plus 3q, saturated
  } quant_res_t;

endpackage

[hw/rtl/fsbd_quant.sv]
// Threshold and error-share datapath for one pixel.
module fsbd_quant (
  input  logic [fsbd_pkg::PIX_W-1:0] pixel_i,
  input  fsbd_pkg::err_t              above_i,
  input  fsbd_pkg::rerr_t             right_err_i,
  input  fsbd_pkg::share_t            pend_br_i,
  input  fsbd_pkg::err_t              held_i,
  output fsbd_pkg::quant_res_t        res_o
);

  logic signed [10:0] sum;
  logic [7:0]         sum_clamped;
  logic               white;
  logic signed [8:0]  err;
  fsbd_pkg::share_t   q;
  logic signed [7:0]  q_x7;
  logic signed [6:0]  q_x5;
  logic signed [5:0]  q_x3;
  logic signed [7:0]  below_sum;
  logic signed [9:0]  left_sum;

  assign sum = $signed({3'b000, pixel_i})
             + $signed({{2{above_i[8]}}, above_i})
             + $signed({{4{right_err_i[6]}}, right_err_i});

  always_comb begin
    if (sum < 0) begin
      sum_clamped = 8'd0;
    end else if (sum > 11'sd255) begin
      sum_clamped = 8'd255;
    end else begin
      sum_clamped = sum[7:0];
    end
  end

  assign white = sum_clamped[7];
  assign err   = $signed({1'b0, sum_clamped}) - (white ? 9'sd255 : 9'sd0);
  // The error lies in -127..127, so its low eight bits shifted right
  // arithmetically by four give the share.
  assign q     = err[7:4];

  assign q_x7 = $signed({q, 3'b000}) - $signed({{4{q[3]}}, q});
  assign q_x5 = $signed({q[3], q, 2'b00}) + $signed({{3{q[3]}}, q});
  assign q_x3 = $signed({q[3], q, 1'b0}) + $signed({{2{q[3]}}, q});

  assign below_sum = $signed({{4{pend_br_i[3]}}, pend_br_i})
                   + $signed({q_x5[6], q_x5});
  assign left_sum  = $signed({held_i[8], held_i})
                   + $signed({{4{q_x3[5]}}, q_x3});

  always_comb begin
    res_o.white     = white;
    res_o.q         = q;
    res_o.right_err = q_x7[6:0];
    res_o.below_new = {below_sum[7], below_sum};
    if (left_sum < -10'sd256) begin
      res_o.below_left = -9'sd256;
    end else if (left_sum > 10'sd255) begin
      res_o.below_left = 9'sd255;
    end else begin
      res_o.below_left = left_sum[8:0];
    end
  end

endmodule

[hw/rtl/floyd_steinberg_binary_dither.sv]
// Top level of the one-bit Floyd-Steinberg dither with byte packing.
//
//  Channel   Direction  tdata                     tuser / tlast
//  s_axis    in         [7:0] pixel               tuser[0] frame_start
//  m_axis    out        [7:0] packed_bits         tlast    row_last
//  cfg       in         [9:0] line_width          (write enable only)
//
// A pixel is taken every clock while s_axis_tready_o is high. It is held in
// the input stage, where the line store is read, then quantized into the
// output register, which offers a byte once the pixel completing it arrives.
// After reset the line store is swept to zero, one entry per cycle, while
// s_axis_tready_o is held low; configuration writes are still taken.
// A stalled output only stops the input when a pixel that completes a byte
// waits in the input stage behind a byte that has not been taken.
module floyd_steinberg_binary_dither (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: line_width, pixels per row.
  input  logic                         cfg_we_i,
  input  logic [fsbd_pkg::CFG_W-1:0]   cfg_wdata_i,
  // Pixel input.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] pixel
  input  logic                         s_axis_tuser_i,  // [0] frame_start
  // Packed output.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,  // [7:0] packed_bits
  output logic                         m_axis_tlast_o   // row_last
);

  localparam int unsigned COL_W = fsbd_pkg::COL_W;
  localparam int unsigned CMP_W = fsbd_pkg::CMP_W;

  // Configuration register.
  logic [fsbd_pkg::CFG_W-1:0] line_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= fsbd_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  // Effective width: rounded down to whole bytes, at least one byte, at most the store.
  logic [CMP_W-1:0] width_raw;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] last_col;

  assign width_raw = CMP_W'(line_width_q) & ~CMP_W'(7);

  always_comb begin
    if (width_raw > fsbd_pkg::WIDTH_LIM) begin
      width_eff = fsbd_pkg::WIDTH_LIM;
    end else if (width_raw < fsbd_pkg::WIDTH_MIN) begin
      width_eff = fsbd_pkg::WIDTH_MIN;
    end else begin
      width_eff = width_raw;
    end
  end

  assign last_col = width_eff - CMP_W'(1);

  // Clearing sweep of the line store after reset.
  logic             clearing_q;
  logic [COL_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + COL_W'(1);
      if (clr_cnt_q == COL_W'(fsbd_pkg::LINE_MAX - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Input stage: column tracking and line store read.
  logic             s1_valid_q;
  logic [7:0]       s1_pix_q;
  logic             s1_fs_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_row_end_q;
  logic             s1_first_q;
  fsbd_pkg::err_t   rd_q;

  logic [COL_W-1:0] column_q;
  logic             first_row_q;

  logic             in_acc;
  logic             s1_consume;
  logic             s1_emit;
  logic             out_free;
  logic [COL_W-1:0] col_in;
  logic             first_in;
  logic             row_end_in;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign s1_emit         = (s1_col_q[2:0] == 3'd7) || s1_row_end_q;
  assign s1_consume      = s1_valid_q && (!s1_emit || out_free);
  assign s_axis_tready_o = !clearing_q && (!s1_valid_q || s1_consume);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign col_in     = s_axis_tuser_i ? '0 : column_q;
  assign first_in   = s_axis_tuser_i || first_row_q;
  assign row_end_in = CMP_W'(col_in) >= last_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        column_q    <= row_end_in ? '0 : col_in + COL_W'(1);
        first_row_q <= first_in && !row_end_in;
        s1_valid_q  <= 1'b1;
      end else if (s1_consume) begin
        s1_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q     <= s_axis_tdata_i;
      s1_fs_q      <= s_axis_tuser_i;
      s1_col_q     <= col_in;
      s1_row_end_q <= row_end_in;
      s1_first_q   <= first_in;
    end
  end

  // Error state carried from pixel to pixel. The newest below entry is held
  // in a register until the next pixel adds its below-left share, then it
  // goes to the line store.
  fsbd_pkg::rerr_t  right_err_q;
  fsbd_pkg::share_t pend_br_q;
  fsbd_pkg::err_t   held_q;
  logic [COL_W-1:0] held_addr_q;
  logic             held_valid_q;
  logic [7:0]       bits_q;

  fsbd_pkg::rerr_t  right_err_cur;
  fsbd_pkg::share_t pend_br_cur;
  fsbd_pkg::err_t   above;
  logic [7:0]       bits_cur;
  logic [7:0]       bits_new;
  fsbd_pkg::quant_res_t qres;

  // A frame start drops the row error and any partly packed byte.
  assign right_err_cur = s1_fs_q ? '0 : right_err_q;
  assign pend_br_cur   = s1_fs_q ? '0 : pend_br_q;
  assign bits_cur      = s1_fs_q ? '0 : bits_q;
  assign above         = s1_first_q ? '0 : rd_q;

  fsbd_quant u_quant (
    .pixel_i     (s1_pix_q),
    .above_i     (above),
    .right_err_i (right_err_cur),
    .pend_br_i   (pend_br_cur),
    .held_i      (held_q),
    .res_o       (qres)
  );

  assign bits_new = {bits_cur[6:0], qres.white};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_err_q  <= '0;
      pend_br_q    <= '0;
      held_valid_q <= 1'b0;
      bits_q       <= '0;
    end else if (s1_consume) begin
      right_err_q  <= s1_row_end_q ? '0 : qres.right_err;
      pend_br_q    <= s1_row_end_q ? '0 : qres.q;
      held_valid_q <= 1'b1;
      bits_q       <= s1_emit ? '0 : bits_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_consume) begin
      held_q      <= qres.below_new;
      held_addr_q <= s1_col_q;
    end
  end

  // Line store: one write port shared by the clearing sweep and the held
  // entry, one registered read port for the pixel being taken. The held
  // entry gets the below-left share only when the current pixel follows it
  // in the same row; otherwise it is written as it stands.
  fsbd_pkg::err_t   line_mem [fsbd_pkg::LINE_MAX];
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  fsbd_pkg::err_t   mem_wdata;

  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_consume && held_valid_q;
      mem_waddr = held_addr_q;
      mem_wdata = (s1_col_q != '0) ? qres.below_left : held_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_q <= line_mem[col_in];
    end
  end

  // Output register: left-justify a short byte at the end of a row.
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_consume && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_consume && s1_emit) begin
      out_data_q <= bits_new << (3'd7 - s1_col_q[2:0]);
      out_last_q <= s1_row_end_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[hw/rtl/fsbd_checker.sv]
// Port-level checks of the dither block and their binding to the top level.
module fsbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // A byte that was not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  // A byte that was not taken keeps its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // Input ready is low during reset and as the clearing sweep of the line store begins.
  a_no_take_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !s_axis_tready_o)
    else $error("input ready during reset");

  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |=> !s_axis_tready_o)
    else $error("input ready before line store clear finished");

  // A new byte can only come from the input stage moving on, which always
  // shows as input ready in the cycle before.
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tready_o))
    else $error("output item without a pixel moving through");

endmodule

bind floyd_steinberg_binary_dither fsbd_checker u_fsbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
